>>> rtl/pwrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrp_pkg
// Shared types, constants and saturation helpers for the prefiltered PID.
// ----------------------------------------------------------------------------
package pwrp_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int FRAC_BITS   = 20;
  localparam int COEF_W      = 32;
  localparam int GAIN_W      = 21;
  localparam int IDX_W       = 4;
  localparam int MUL_A_W     = 42;
  localparam int MUL_B_W     = 48;
  localparam int PROD_W      = 64;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_NUM0  = 4'd0;
  localparam logic [IDX_W-1:0] REG_NUM1  = 4'd1;
  localparam logic [IDX_W-1:0] REG_DEN1  = 4'd2;
  localparam logic [IDX_W-1:0] REG_DEN2  = 4'd3;
  localparam logic [IDX_W-1:0] REG_PROP  = 4'd4;
  localparam logic [IDX_W-1:0] REG_INTEG = 4'd5;
  localparam logic [IDX_W-1:0] REG_DERIV = 4'd6;
  localparam logic [IDX_W-1:0] REG_LPG   = 4'd7;

  localparam logic signed [COEF_W-1:0] ONE_COEF = COEF_W'(64'sd1 <<< FRAC_BITS);
  localparam logic [GAIN_W-1:0]        HALF_GAIN = GAIN_W'(64'd1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic signed [COEF_W-1:0] num0;
    logic signed [COEF_W-1:0] num1;
    logic signed [COEF_W-1:0] den1;
    logic signed [COEF_W-1:0] den2;
    logic signed [COEF_W-1:0] prop;
    logic signed [COEF_W-1:0] integ;
    logic signed [COEF_W-1:0] deriv;
    logic [GAIN_W-1:0]        lpg;
  } coef_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi)      sat32 = hi[31:0];
    else if (v < lo) sat32 = lo[31:0];
    else             sat32 = v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_007F_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi)      sat40 = hi[39:0];
    else if (v < lo) sat40 = lo[39:0];
    else             sat40 = v[39:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/pwrp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrp_mul
// Shared signed multiplier: 42-bit operand times 48-bit operand, one 16-bit
// digit of the second operand per cycle, partial products accumulated.
// ----------------------------------------------------------------------------
module pwrp_mul import pwrp_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic signed [MUL_B_W-1:0] b_i,
  output mul_res_t                       res_o
);

  logic signed [MUL_A_W-1:0]    a_q;
  logic signed [MUL_B_W-1:0]    b_q;
  logic [1:0]                   cnt_q;
  logic                         busy_q;
  logic                         done_q;
  logic signed [MUL_A_W+16:0]   pp_q;
  logic signed [PROD_W-1:0]     acc_q;
  logic signed [16:0]           digit;
  logic signed [PROD_W-1:0]     pp_ext;
  logic signed [PROD_W-1:0]     pp_sh;

  always_comb begin
    case (cnt_q)
      2'd0:    digit = $signed({1'b0, b_q[15:0]});
      2'd1:    digit = $signed({1'b0, b_q[31:16]});
      2'd2:    digit = $signed({b_q[47], b_q[47:32]});
      default: digit = '0;
    endcase
  end

  assign pp_ext = PROD_W'(pp_q);

  // The partial product in pp_q belongs to the previous digit.
  always_comb begin
    case (cnt_q)
      2'd2:    pp_sh = pp_ext <<< 16;
      2'd3:    pp_sh = pp_ext <<< 32;
      default: pp_sh = pp_ext;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 2'd3) pp_q <= a_q * digit;
      if (cnt_q != 2'd0) acc_q <= acc_q + pp_sh;
    end
  end

  assign res_o.done = done_q;
  assign res_o.prod = acc_q;

endmodule
`default_nettype wire

>>> rtl/pwrp_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrp_regs
// Coefficient register file written through the configuration port.
// ----------------------------------------------------------------------------
module pwrp_regs import pwrp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire logic [COEF_W-1:0] data_i,
  output coef_t                  coef_o
);

  coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{num0: ONE_COEF, num1: '0, den1: '0, den2: '0,
                  prop: ONE_COEF, integ: '0, deriv: '0, lpg: HALF_GAIN};
    end else if (we_i) begin
      case (idx_i)
        REG_NUM0:  coef_q.num0  <= $signed(data_i);
        REG_NUM1:  coef_q.num1  <= $signed(data_i);
        REG_DEN1:  coef_q.den1  <= $signed(data_i);
        REG_DEN2:  coef_q.den2  <= $signed(data_i);
        REG_PROP:  coef_q.prop  <= $signed(data_i);
        REG_INTEG: coef_q.integ <= $signed(data_i);
        REG_DERIV: coef_q.deriv <= $signed(data_i);
        REG_LPG:   coef_q.lpg   <= data_i[GAIN_W-1:0];
        default:   ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

>>> rtl/pid_with_reference_prefilter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_with_reference_prefilter_top
// Two-degree-of-freedom PID with setpoint prefilter, anti-windup and output
// low-pass, computed by one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// cfg       in         cfg_we_i                 cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_ready_o  measured_i, setpoint_i,
//                                               clear_integral_i
// out       out        out_valid_o / out_ready_i drive_o, clamped_o
//
// Each sample runs ten products on the shared multiplier, each started in
// MSTART and collected in MWAIT, plus the YREF, ERR, DIFF, X and OUT add,
// saturate and output steps. The next sample is taken in IDLE after OUT, so
// the block takes no new sample before it is through with the last one.
// Reset is asynchronous and restores coefficients and all filter history.
// A result may wait on the output register while the next sample is taken;
// the sequencer only stalls in its last step if that register is still full.
// ----------------------------------------------------------------------------
module pid_with_reference_prefilter_top import pwrp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [IDX_W-1:0]       cfg_idx_i,
  input  wire logic [COEF_W-1:0]      cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] measured_i,
  input  wire logic [SAMPLE_BITS-1:0] setpoint_i,
  input  wire logic                   clear_integral_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0]      drive_o,
  output logic                        clamped_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MSTART = 3'd1;
  localparam logic [2:0] ST_MWAIT  = 3'd2;
  localparam logic [2:0] ST_YREF   = 3'd3;
  localparam logic [2:0] ST_ERR    = 3'd4;
  localparam logic [2:0] ST_DIFF   = 3'd5;
  localparam logic [2:0] ST_X      = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  localparam logic [3:0] OP_NUM0  = 4'd0;
  localparam logic [3:0] OP_NUM1  = 4'd1;
  localparam logic [3:0] OP_NUM2  = 4'd2;
  localparam logic [3:0] OP_DEN1  = 4'd3;
  localparam logic [3:0] OP_DEN2  = 4'd4;
  localparam logic [3:0] OP_PROP  = 4'd5;
  localparam logic [3:0] OP_INTEG = 4'd6;
  localparam logic [3:0] OP_DERIV = 4'd7;
  localparam logic [3:0] OP_LPIN  = 4'd8;
  localparam logic [3:0] OP_LPFB  = 4'd9;

  localparam logic signed [63:0] FULL_SCALE = 64'sd1 <<< (SAMPLE_BITS + FRAC_BITS);
  localparam logic signed [MUL_B_W-1:0] ONE_B = MUL_B_W'(64'sd1 <<< FRAC_BITS);
  localparam logic [SAMPLE_BITS-1:0] DRIVE_MAX = '1;

  coef_t    coef;
  mul_res_t mres;

  logic [2:0] state_q, state_d;
  logic [3:0] op_q;

  logic [SAMPLE_BITS-1:0] meas_q, sp_q, h0_q, h1_q;
  logic signed [34:0]     num2_q;
  logic signed [31:0]     oh0_q, oh1_q, err_q, diff_q, last_q;
  logic signed [39:0]     integ_q, x_q, lin_q, lout_q;
  logic signed [63:0]     sum_q, p_q, d_q;
  logic                   integ_en_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] drive_q;
  logic                   clamped_q;

  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [63:0]        prod_sh;
  logic signed [63:0]        err_full;
  logic signed [39:0]        y_sat;
  logic                      in_xfer;
  logic                      out_free;

  pwrp_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .coef_o (coef)
  );

  pwrp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mres)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign mul_start  = (state_q == ST_MSTART);
  assign prod_sh    = mres.prod >>> FRAC_BITS;
  assign y_sat      = sat40(sum_q);

  always_comb begin
    case (op_q)
      OP_NUM0:  begin mul_a = MUL_A_W'(coef.num0);  mul_b = MUL_B_W'(sp_q);   end
      OP_NUM1:  begin mul_a = MUL_A_W'(coef.num1);  mul_b = MUL_B_W'(h0_q);   end
      OP_NUM2:  begin mul_a = MUL_A_W'(num2_q);     mul_b = MUL_B_W'(h1_q);   end
      OP_DEN1:  begin mul_a = MUL_A_W'(coef.den1);  mul_b = MUL_B_W'(oh0_q);  end
      OP_DEN2:  begin mul_a = MUL_A_W'(coef.den2);  mul_b = MUL_B_W'(oh1_q);  end
      OP_PROP:  begin mul_a = MUL_A_W'(coef.prop);  mul_b = MUL_B_W'(err_q);  end
      OP_INTEG: begin mul_a = MUL_A_W'(coef.integ); mul_b = MUL_B_W'(err_q);  end
      OP_DERIV: begin mul_a = MUL_A_W'(coef.deriv); mul_b = MUL_B_W'(diff_q); end
      OP_LPIN: begin
        mul_a = MUL_A_W'(x_q) + MUL_A_W'(lin_q);
        mul_b = MUL_B_W'({1'b0, coef.lpg});
      end
      OP_LPFB: begin
        mul_a = MUL_A_W'(lout_q);
        mul_b = MUL_B_W'({1'b0, coef.lpg, 1'b0}) - ONE_B;
      end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign err_full = 64'(oh0_q) - $signed(64'(meas_q) << FRAC_BITS);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MSTART;
      ST_MSTART: state_d = ST_MWAIT;
      ST_MWAIT: begin
        if (mres.done) begin
          case (op_q)
            OP_DEN2:  state_d = ST_YREF;
            OP_DERIV: state_d = ST_X;
            OP_LPFB:  state_d = ST_OUT;
            default:  state_d = ST_MSTART;
          endcase
        end
      end
      ST_YREF:   state_d = ST_ERR;
      ST_ERR:    state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_MSTART;
      ST_X:      state_d = ST_MSTART;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NUM0;
      out_valid_q <= 1'b0;
      h0_q        <= '0;
      h1_q        <= '0;
      oh0_q       <= '0;
      oh1_q       <= '0;
      integ_q     <= '0;
      last_q      <= '0;
      lin_q       <= '0;
      lout_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            op_q <= OP_NUM0;
            if (clear_integral_i) integ_q <= '0;
          end
        end
        ST_MWAIT: begin
          if (mres.done) begin
            op_q <= op_q + 4'd1;
            case (op_q)
              OP_NUM0:  sum_q <= mres.prod;
              OP_NUM1,
              OP_NUM2:  sum_q <= sum_q + mres.prod;
              OP_DEN1,
              OP_DEN2:  sum_q <= sum_q - prod_sh;
              OP_PROP:  p_q <= prod_sh;
              OP_INTEG: if (integ_en_q) integ_q <= sat40(64'(integ_q) + prod_sh);
              OP_DERIV: d_q <= prod_sh;
              OP_LPIN:  sum_q <= prod_sh;
              OP_LPFB:  sum_q <= sum_q - prod_sh;
              default:  ;
            endcase
          end
        end
        ST_YREF: begin
          h1_q  <= h0_q;
          h0_q  <= sp_q;
          oh1_q <= oh0_q;
          oh0_q <= sat32(sum_q);
        end
        ST_ERR:  err_q <= sat32(err_full);
        ST_DIFF: begin
          diff_q <= sat32(64'(err_q) - 64'(last_q));
          last_q <= err_q;
        end
        ST_X: x_q <= sat40(p_q + 64'(integ_q) + d_q);
        ST_OUT: begin
          if (out_free) begin
            lin_q  <= x_q;
            lout_q <= y_sat;
          end
        end
        default: ;
      endcase
    end
  end

  // Sample latch and coefficient preparation at the input transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      meas_q <= measured_i;
      sp_q   <= setpoint_i;
      num2_q <= 35'(ONE_COEF) + 35'(coef.den1) + 35'(coef.den2)
                - 35'(coef.num0) - 35'(coef.num1);
    end
  end

  // Clamp the freshly filtered value while it is written to the history.
  logic y_hi_n, y_lo_n, y_top_n;
  assign y_hi_n  = 64'(y_sat) > FULL_SCALE;
  assign y_lo_n  = y_sat < 40'sd0;
  assign y_top_n = y_sat[39:FRAC_BITS] > DRIVE_MAX;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      if (y_hi_n) begin
        drive_q   <= DRIVE_MAX;
        clamped_q <= 1'b1;
      end else if (y_lo_n) begin
        drive_q   <= '0;
        clamped_q <= 1'b1;
      end else begin
        drive_q   <= y_top_n ? DRIVE_MAX : y_sat[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
        clamped_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_en_q <= 1'b1;
    end else if (state_q == ST_OUT && out_free) begin
      integ_en_q <= !(y_hi_n || y_lo_n);
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

endmodule
`default_nettype wire

>>> rtl/pwrp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrp_checker
// Port-level checks of the prefiltered PID, bound to the top level.
// ----------------------------------------------------------------------------
module pwrp_checker import pwrp_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   cfg_we_i,
  input wire logic [IDX_W-1:0]       cfg_idx_i,
  input wire logic [COEF_W-1:0]      cfg_data_i,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic [SAMPLE_BITS-1:0] measured_i,
  input wire logic [SAMPLE_BITS-1:0] setpoint_i,
  input wire logic                   clear_integral_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [SAMPLE_BITS-1:0] drive_o,
  input wire logic                   clamped_o
);

  localparam logic [SAMPLE_BITS-1:0] DRIVE_MAX = '1;

  // A waiting result keeps its payload until the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o) && $stable(clamped_o))
    else $error("output payload changed while stalled");

  // A clamped result always sits on one of the two rails.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamped_o |-> drive_o == '0 || drive_o == DRIVE_MAX)
    else $error("clamp flag without rail value");

  // After an input transfer the block is busy for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken during computation");

  // No result appears right after an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind pid_with_reference_prefilter_top pwrp_checker u_pwrp_checker (.*);
`default_nettype wire
